@@ rtl/pwl_pkg.sv @@
// Shared types and constants of the piecewise-linear table interpolator.
// Holds the request and response transaction structs, register map and codes.
// No dependencies.
package pwl_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (word address, byte address divided by four).
  localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

  // Reset value of the entries_in_use register.
  localparam logic [5:0] ENTRIES_RESET = 6'd32;

  // Request function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Response status codes.
  localparam logic [1:0] STATUS_INTERP     = 2'd0;
  localparam logic [1:0] STATUS_CLAMP_LO   = 2'd1;
  localparam logic [1:0] STATUS_CLAMP_HI   = 2'd2;
  localparam logic [1:0] STATUS_WRITE_DONE = 2'd3;

  typedef struct packed {
    logic               func;
    logic        [4:0]  entry_index;
    logic        [31:0] point_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic        [5:0]  segment;
    logic        [1:0]  status;
  } rsp_t;

endpackage

@@ rtl/pwl_muldiv.sv @@
// Iterative scaled-quotient unit: computes floor(mag * dx / den), one bit of mag per cycle.
// Requires dx <= den and den > 0. No package dependencies.
module pwl_muldiv #(
  parameter int unsigned MAG_W = 32,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [DEN_W-1:0] dx_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [MAG_W-1:0] quot_o
);

  localparam int unsigned ACC_W = DEN_W + 2;
  localparam int unsigned CNT_W = $clog2(MAG_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0] mag_q;
  logic [DEN_W-1:0] dx_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [MAG_W-1:0] quot_q;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] den1;
  logic [ACC_W-1:0] den2;
  logic             ge1;
  logic             ge2;
  logic [ACC_W-1:0] rem_d;
  logic [1:0]       digit;
  logic [MAG_W-1:0] quot_d;

  // The remainder stays below den, so 2*rem + dx stays below 3*den and the
  // quotient digit of each step is 0, 1 or 2.
  assign acc   = ACC_W'({rem_q, 1'b0}) + (mag_q[MAG_W-1] ? ACC_W'(dx_q) : '0);
  assign den1  = ACC_W'(den_q);
  assign den2  = ACC_W'({den_q, 1'b0});
  assign ge2   = (acc >= den2);
  assign ge1   = (acc >= den1);
  assign rem_d = ge2 ? (acc - den2) : (ge1 ? (acc - den1) : acc);
  assign digit = {ge2, ge1 & ~ge2};
  assign quot_d = {quot_q[MAG_W-2:0], 1'b0} + MAG_W'(digit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= mag_i;
      dx_q   <= dx_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      mag_q  <= {mag_q[MAG_W-2:0], 1'b0};
      rem_q  <= rem_d[DEN_W-1:0];
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef ASSERT_OFF
  a_start_operands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (den_i != '0) && (dx_i <= den_i))
    else $error("scaled quotient started with invalid operands");

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("scaled quotient restarted while busy");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");
`endif

endmodule

@@ rtl/piecewise_linear_table_interp.sv @@
// Top level of the piecewise-linear table interpolator: breakpoint memory, scan
// sequencer, result register and configuration port. Uses pwl_pkg and pwl_muldiv.
//
//  Channel   | Signals                             | Handshake
//  ----------+-------------------------------------+-------------------------------
//  request   | start, busy, req_i                  | taken when start & !busy
//  result    | result_valid_o, rsp_o               | one-cycle strobe, no stall
//  config    | psel, penable, pwrite, paddr,       | APB, write on access phase,
//            | pwdata, prdata, pready              | pready tied high
//
// A write transaction's result strobes in the next cycle and busy stays low.
// A query scans breakpoints one per cycle through the single memory read port, and an interior
// query then runs the shared scaled-quotient unit once for each y value. Reset clears the
// control state and sets entries_in_use to 32; the table is not cleared. The result strobe
// lasts exactly one cycle and cannot be held off.
module piecewise_linear_table_interp #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned X_WIDTH     = 32,
  parameter int unsigned Y_WIDTH     = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  pwl_pkg::req_t                        req_i,
  output logic                                 result_valid_o,
  output pwl_pkg::rsp_t                        rsp_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwl_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [pwl_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [pwl_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import pwl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned N_W   = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_DIV   = 4'b1000
  } state_e;

  typedef struct packed {
    logic        [X_WIDTH-1:0] x;
    logic signed [Y_WIDTH-1:0] ya;
    logic signed [Y_WIDTH-1:0] yb;
  } entry_t;

  // Breakpoint memory: one write port, one registered read port.
  entry_t           mem [MAX_ENTRIES];
  entry_t           rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;
  entry_t           wr_data;

  state_e           state_q, state_d;
  logic             valid_q;
  logic [5:0]       entries_q;
  logic [N_W-1:0]   cnt_q;
  logic             lane_q;
  logic             neg_q;
  logic [X_WIDTH-1:0] x_q;
  entry_t           prev_q;
  entry_t           cur_q;
  rsp_t             rsp_q;

  logic             accept;
  logic             acc_write;
  logic             acc_query;
  logic             cfg_we;
  logic [N_W-1:0]   n_eff;
  logic [N_W-1:0]   cnt_next;
  logic             scan_hit;
  logic             scan_first;
  logic             scan_last;
  logic             degenerate;
  logic             finish;

  logic signed [Y_WIDTH-1:0] y0;
  logic signed [Y_WIDTH-1:0] y1;
  logic                      neg;
  logic [Y_WIDTH-1:0]        mag;
  logic [X_WIDTH-1:0]        den;
  logic [X_WIDTH-1:0]        dx;
  logic signed [Y_WIDTH-1:0] res;

  logic               md_start;
  logic               md_done;
  logic [Y_WIDTH-1:0] md_quot;

  // ---------------------------------------------------------------------------
  // Configuration port. A single register, entries_in_use, at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_ENTRIES_IN_USE);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_ENTRIES_IN_USE) ?
                  CFG_DATA_W'(entries_q) : '0;

  // Register values outside 1..MAX_ENTRIES are clamped into range.
  assign n_eff = (entries_q == '0)         ? N_W'(1) :
                 (entries_q > MAX_ENTRIES) ? N_W'(MAX_ENTRIES) : N_W'(entries_q);

  // ---------------------------------------------------------------------------
  // Request decode and breakpoint memory.
  // ---------------------------------------------------------------------------
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign acc_write = accept && (req_i.func == FUNC_WRITE);
  assign acc_query = accept && (req_i.func == FUNC_QUERY);

  // A write beyond the table depth stores nothing but still completes.
  assign mem_we     = acc_write && (req_i.entry_index < MAX_ENTRIES);
  assign wr_addr    = IDX_W'(req_i.entry_index);
  assign wr_data.x  = X_WIDTH'(req_i.point_x);
  // The field bits are taken as they stand; the sign sits at bit Y_WIDTH-1.
  assign wr_data.ya = Y_WIDTH'($unsigned(req_i.first_y));
  assign wr_data.yb = Y_WIDTH'($unsigned(req_i.second_y));

  // While idle the read port points at entry zero, so the scan finds entry zero
  // in rd_q on its first cycle; during the scan it prefetches the next entry.
  assign cnt_next = cnt_q + 1'b1;
  assign rd_addr  = (state_q == ST_SCAN) ? cnt_next[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Scan decisions. rd_q holds entry cnt_q, prev_q holds entry cnt_q-1.
  // ---------------------------------------------------------------------------
  assign scan_hit   = (x_q <= rd_q.x);
  assign scan_first = (cnt_q == '0);
  assign scan_last  = (cnt_next == n_eff);
  // A segment whose ends do not ascend cannot be interpolated; the lower pair
  // is returned instead.
  assign degenerate = (rd_q.x <= prev_q.x) || (x_q < prev_q.x);

  // ---------------------------------------------------------------------------
  // Interpolation operands for the current lane (0 = bias, 1 = fluctuation).
  // ---------------------------------------------------------------------------
  assign y0  = lane_q ? prev_q.yb : prev_q.ya;
  assign y1  = lane_q ? cur_q.yb  : cur_q.ya;
  assign neg = (y1 < y0);
  assign mag = neg ? Y_WIDTH'(y0 - y1) : Y_WIDTH'(y1 - y0);
  assign den = cur_q.x - prev_q.x;
  assign dx  = x_q - prev_q.x;
  // The quotient never exceeds the magnitude, so the sum stays between y0 and y1.
  assign res = neg_q ? $signed($unsigned(y0) - md_quot) : $signed($unsigned(y0) + md_quot);

  assign md_start = (state_q == ST_SETUP);

  pwl_muldiv #(
    .MAG_W (Y_WIDTH),
    .DEN_W (X_WIDTH)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_i   (mag),
    .dx_i    (dx),
    .den_i   (den),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_query) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = (scan_first || degenerate) ? ST_IDLE : ST_SETUP;
        end else if (scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SETUP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (md_done) begin
          state_d = lane_q ? ST_IDLE : ST_SETUP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The result transaction is presented in the cycle after the work completes.
  assign finish = acc_write ||
                  ((state_q == ST_SCAN) &&
                   ((scan_hit && (scan_first || degenerate)) || (!scan_hit && scan_last))) ||
                  ((state_q == ST_DIV) && md_done && lane_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      entries_q <= ENTRIES_RESET;
      cnt_q     <= '0;
      lane_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= finish;
      if (cfg_we) begin
        entries_q <= pwdata[5:0];
      end
      if (acc_query) begin
        cnt_q  <= '0;
        lane_q <= 1'b0;
      end else if ((state_q == ST_SCAN) && !scan_hit) begin
        cnt_q <= cnt_next;
      end else if ((state_q == ST_DIV) && md_done) begin
        lane_q <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      x_q <= X_WIDTH'(req_i.point_x);
    end
    if (acc_write) begin
      rsp_q.first_result  <= '0;
      rsp_q.second_result <= '0;
      rsp_q.segment       <= '0;
      rsp_q.status        <= STATUS_WRITE_DONE;
    end
    if (state_q == ST_SCAN) begin
      if (scan_hit) begin
        cur_q         <= rd_q;
        rsp_q.segment <= 6'(cnt_q);
        if (scan_first) begin
          rsp_q.first_result  <= 32'(rd_q.ya);
          rsp_q.second_result <= 32'(rd_q.yb);
          rsp_q.status        <= STATUS_CLAMP_LO;
        end else begin
          // Final for a degenerate segment, replaced by interpolation otherwise.
          rsp_q.first_result  <= 32'(prev_q.ya);
          rsp_q.second_result <= 32'(prev_q.yb);
          rsp_q.status        <= STATUS_INTERP;
        end
      end else begin
        prev_q <= rd_q;
        if (scan_last) begin
          rsp_q.first_result  <= 32'(rd_q.ya);
          rsp_q.second_result <= 32'(rd_q.yb);
          rsp_q.segment       <= 6'(cnt_next);
          rsp_q.status        <= STATUS_CLAMP_HI;
        end
      end
    end
    if (state_q == ST_SETUP) begin
      neg_q <= neg;
    end
    if ((state_q == ST_DIV) && md_done) begin
      if (lane_q) begin
        rsp_q.second_result <= 32'(res);
      end else begin
        rsp_q.first_result <= 32'(res);
      end
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

`ifndef ASSERT_OFF
  a_query_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_query |=> busy)
    else $error("query transaction accepted without going busy");

  a_clamp_hi_segment : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == STATUS_CLAMP_HI)) |-> (rsp_o.segment == 6'(n_eff)))
    else $error("clamped-high result with wrong segment");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == ST_DIV))
    else $error("quotient finished outside the divide state");
`endif

endmodule
